// File: src/sed_pkg.sv
package sed_pkg;

    localparam int BLOCK_LEN      = 2048;
    localparam int PREROLL_BLOCKS = 2;
    localparam int IDX_W          = $clog2(BLOCK_LEN);
    localparam int PTR_W          = (PREROLL_BLOCKS > 1) ? $clog2(PREROLL_BLOCKS) : 1;

    localparam int PEAK_W  = 15;
    localparam int LEVEL_W = 7;
    localparam int SUM_W   = 15;
    localparam int CNT_W   = 8;
    localparam int MIN_W   = 10;
    localparam int CAP_W   = 12;
    localparam int CFG_W   = 12;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_ARM    = 2'd1;
    localparam logic [1:0] ACT_DISARM = 2'd2;

    localparam logic [1:0] MODE_DETECT  = 2'd0;
    localparam logic [1:0] MODE_SILENCE = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_REC  = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    localparam logic [2:0] V_DISCARD = 3'd0;
    localparam logic [2:0] V_PREROLL = 3'd1;
    localparam logic [2:0] V_STORE   = 3'd2;
    localparam logic [2:0] V_SKIP    = 3'd3;
    localparam logic [2:0] V_END     = 3'd4;
    localparam logic [2:0] V_SILENCE = 3'd5;
    localparam logic [2:0] V_FOUND   = 3'd6;

    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_START    = 3'd1;
    localparam logic [2:0] CFG_STOP     = 3'd2;
    localparam logic [2:0] CFG_QUIET    = 3'd3;
    localparam logic [2:0] CFG_TAIL     = 3'd4;
    localparam logic [2:0] CFG_CAPACITY = 3'd5;
    localparam logic [2:0] CFG_CALIB    = 3'd6;

    localparam logic [MIN_W-1:0] MIN_RESET = 10'd1000;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] sample;
    } sed_in_t;

    typedef struct packed {
        logic [2:0]         verdict;
        logic [LEVEL_W-1:0] block_level;
        logic [LEVEL_W-1:0] found_level;
        logic               preroll_slot;
        logic               recording;
    } sed_out_t;

    typedef struct packed {
        logic take;
        logic level;
        logic decide;
        logic div_start;
        logic emit;
    } sed_cmd_t;

    typedef struct packed {
        logic block_end;
        logic need_div;
        logic div_done;
        logic out_free;
    } sed_stat_t;

endpackage

// File: src/speech_endpoint_detector_core.sv
// speech endpoint detector: block peak level, pre-roll, record, tail and calibration
//
// input channel s_valid/s_ready/s_data carries one request per audio sample or
// an arm / disarm event. samples are taken one per cycle outside a block end:
// the request that closes a block holds the input while the level multiply,
// the phase decision and the load into the output register run in turn, and
// the load waits for a free output register. a speech start level calibration
// that ends with counted blocks sends the mean through a 15-step serial divider.
// m_valid/m_ready/m_data gives one result per finished block while armed;
// the output register lets the next samples in while a result waits, and only
// a following block end waits for m_ready. configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata); the user must write it only while no request
// is in flight, and the block itself does not enforce this.
// reset (aresetn low, synchronous) restores the register defaults, drops
// the output and leaves the detector disarmed.
module speech_endpoint_detector_core
    import sed_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sed_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sed_out_t         m_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    sed_cmd_t  cmd;
    sed_stat_t stat;

    sed_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sed_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: src/sed_div.sv
module sed_div
    import sed_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    rem_shift;
    logic              bit_ok;

    // one restoring step: dividend bits leave at the top, quotient bits enter below
    always_comb begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        bit_ok    = rem_shift >= {1'b0, div_reg};
        rem_next  = bit_ok ? CNT_W'(rem_shift - {1'b0, div_reg}) : rem_shift[CNT_W-1:0];
        quo_next  = {quo_reg[SUM_W-2:0], bit_ok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/sed_datapath.sv
module sed_datapath
    import sed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  sed_cmd_t   cmd,
    output sed_stat_t  stat,
    input  sed_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output sed_out_t   m_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // configuration
    logic [1:0]         mode_reg;
    logic [LEVEL_W-1:0] start_lvl_reg;
    logic [LEVEL_W-1:0] stop_lvl_reg;
    logic [3:0]         quiet_need_reg;
    logic [3:0]         tail_cfg_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   calib_cfg_reg;

    // detector state
    logic [1:0]         phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PEAK_W-1:0]  peak_reg, peak_next;
    logic [PEAK_W-1:0]  end_peak_reg, end_peak_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [3:0]         quiet_reg, quiet_next;
    logic [3:0]         tail_reg, tail_next;
    logic [CAP_W-1:0]   stored_reg, stored_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [CNT_W-1:0]   calib_reg, calib_next;

    // pending result
    logic [2:0]         res_verdict_reg, res_verdict_next;
    logic               res_slot_reg, res_slot_next;
    logic               res_rec_reg, res_rec_next;
    logic               res_found_reg, res_found_next;

    logic               m_valid_reg;
    sed_out_t           m_data_reg;

    logic               div_done;
    logic [SUM_W-1:0]   quotient;
    logic [PEAK_W-1:0]  sample_peak;
    logic               can_store;
    logic               near_full;
    logic [PEAK_W+LEVEL_W-1:0] level_prod;
    logic [MIN_W:0]     found_sum;
    logic [MIN_W+10:0]  found_prod;
    logic [LEVEL_W-1:0] found_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_DETECT;
            start_lvl_reg  <= 7'd0;
            stop_lvl_reg   <= 7'd3;
            quiet_need_reg <= 4'd4;
            tail_cfg_reg   <= 4'd1;
            cap_reg        <= 12'd1500;
            calib_cfg_reg  <= 8'd50;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:     mode_reg       <= cfg_wdata[1:0];
                CFG_START:    start_lvl_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_STOP:     stop_lvl_reg   <= cfg_wdata[LEVEL_W-1:0];
                CFG_QUIET:    quiet_need_reg <= cfg_wdata[3:0];
                CFG_TAIL:     tail_cfg_reg   <= cfg_wdata[3:0];
                CFG_CAPACITY: cap_reg        <= cfg_wdata[CAP_W-1:0];
                CFG_CALIB:    calib_cfg_reg  <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // positive samples only
    assign sample_peak = (!s_data.sample[15] && (s_data.sample[14:0] > peak_reg))
                         ? s_data.sample[14:0] : peak_reg;

    assign can_store = ({1'b0, stored_reg} + 13'd1) < {1'b0, cap_reg};
    assign near_full = {1'b0, cap_reg} <
                       ({1'b0, stored_reg} + 13'(2 * (1 + PREROLL_BLOCKS))
                        + {8'd0, tail_cfg_reg, 1'b0});

    always_comb begin
        phase_next       = phase_reg;
        idx_next         = idx_reg;
        peak_next        = peak_reg;
        end_peak_next    = end_peak_reg;
        quiet_next       = quiet_reg;
        tail_next        = tail_reg;
        stored_next      = stored_reg;
        ptr_next         = ptr_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        min_next         = min_reg;
        calib_next       = calib_reg;
        res_verdict_next = res_verdict_reg;
        res_slot_next    = res_slot_reg;
        res_rec_next     = res_rec_reg;
        res_found_next   = res_found_reg;

        if (cmd.take) begin
            if (s_data.action == ACT_ARM) begin
                phase_next  = PH_WAIT;
                idx_next    = '0;
                peak_next   = '0;
                quiet_next  = '0;
                tail_next   = tail_cfg_reg;
                stored_next = '0;
                ptr_next    = '0;
                sum_next    = '0;
                count_next  = '0;
                min_next    = MIN_RESET;
                calib_next  = calib_cfg_reg;
            end else if (s_data.action == ACT_DISARM) begin
                phase_next = PH_IDLE;
                idx_next   = '0;
                peak_next  = '0;
            end else if (s_data.action == ACT_SAMPLE && phase_reg != PH_IDLE) begin
                if (stat.block_end) begin
                    idx_next      = '0;
                    peak_next     = '0;
                    end_peak_next = sample_peak;
                end else begin
                    idx_next  = idx_reg + 1'b1;
                    peak_next = sample_peak;
                end
            end
        end else if (cmd.decide) begin
            res_verdict_next = V_DISCARD;
            res_slot_next    = 1'b0;
            res_found_next   = 1'b0;
            case (mode_reg)
                MODE_SILENCE: res_verdict_next = V_SILENCE;
                MODE_START: begin
                    if (calib_reg <= 8'd1) begin
                        calib_next       = '0;
                        res_found_next   = count_reg != '0;
                        res_verdict_next = V_FOUND;
                        phase_next       = PH_IDLE;
                    end else begin
                        calib_next = calib_reg - 1'b1;
                        if (level_reg > stop_lvl_reg) begin
                            sum_next   = sum_reg + SUM_W'(level_reg);
                            count_next = count_reg + 1'b1;
                            if ({3'd0, level_reg} < min_reg) begin
                                min_next = {3'd0, level_reg};
                            end
                        end
                    end
                end
                MODE_DETECT: begin
                    if (phase_reg == PH_WAIT) begin
                        res_slot_next    = ptr_reg[0];
                        ptr_next         = (ptr_reg == PTR_W'(PREROLL_BLOCKS - 1))
                                           ? '0 : ptr_reg + 1'b1;
                        res_verdict_next = V_PREROLL;
                        if (level_reg >= start_lvl_reg) begin
                            phase_next = PH_REC;
                        end
                    end else if (phase_reg == PH_TAIL) begin
                        if (tail_reg != '0) begin
                            tail_next = tail_reg - 1'b1;
                            if (can_store) begin
                                stored_next      = stored_reg + 1'b1;
                                res_verdict_next = V_STORE;
                            end
                        end else begin
                            res_verdict_next = V_END;
                            phase_next       = PH_IDLE;
                        end
                    end else begin
                        if (quiet_reg >= quiet_need_reg) begin
                            phase_next       = PH_TAIL;
                            quiet_next       = '0;
                            res_verdict_next = V_SKIP;
                        end else begin
                            if (level_reg <= stop_lvl_reg) begin
                                if (quiet_reg != 4'd15) begin
                                    quiet_next = quiet_reg + 1'b1;
                                end
                            end else begin
                                quiet_next = '0;
                            end
                            if (near_full) begin
                                phase_next = PH_TAIL;
                            end
                            if (can_store) begin
                                stored_next      = stored_reg + 1'b1;
                                res_verdict_next = V_STORE;
                            end
                        end
                    end
                end
                default: ;
            endcase
            res_rec_next = (phase_next == PH_REC) || (phase_next == PH_TAIL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            idx_reg    <= '0;
            peak_reg   <= '0;
            quiet_reg  <= '0;
            tail_reg   <= '0;
            stored_reg <= '0;
            ptr_reg    <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            min_reg    <= MIN_RESET;
            calib_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            peak_reg   <= peak_next;
            quiet_reg  <= quiet_next;
            tail_reg   <= tail_next;
            stored_reg <= stored_next;
            ptr_reg    <= ptr_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            calib_reg  <= calib_next;
        end
    end

    assign level_prod = end_peak_reg * 7'd100;

    always_ff @(posedge aclk) begin
        end_peak_reg    <= end_peak_next;
        res_verdict_reg <= res_verdict_next;
        res_slot_reg    <= res_slot_next;
        res_rec_reg     <= res_rec_next;
        res_found_reg   <= res_found_next;
        if (cmd.level) begin
            level_reg <= level_prod[PEAK_W+LEVEL_W-1:PEAK_W];
        end
    end

    sed_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // (2*mean + min) / 3, divide by three as multiply by 683 and shift by 11
    assign found_sum  = {quotient[MIN_W-2:0], 1'b0} + {1'b0, min_reg};
    assign found_prod = found_sum * 10'd683;
    assign found_val  = found_prod[LEVEL_W+10:11];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.verdict      <= res_verdict_reg;
            m_data_reg.block_level  <= level_reg;
            m_data_reg.found_level  <= res_found_reg ? found_val : '0;
            m_data_reg.preroll_slot <= res_slot_reg;
            m_data_reg.recording    <= res_rec_reg;
        end
    end

    assign stat.block_end = (s_data.action == ACT_SAMPLE) && (phase_reg != PH_IDLE)
                            && (idx_reg == IDX_W'(BLOCK_LEN - 1));
    assign stat.need_div  = (mode_reg == MODE_START) && (calib_reg <= 8'd1)
                            && (count_reg != '0);
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/sed_ctrl.sv
module sed_ctrl
    import sed_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sed_stat_t stat,
    output sed_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_ACCEPT = 5'b00001,
        ST_LEVEL  = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_ACCEPT: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && stat.block_end) begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                cmd.level  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide    = 1'b1;
                cmd.div_start = stat.need_div;
                state_next    = stat.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/sed_checker.sv
module sed_checker
    import sed_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input sed_in_t          s_data,
    input logic             m_valid,
    input logic             m_ready,
    input sed_out_t         m_data,
    input logic             cfg_we,
    input logic [2:0]       cfg_index,
    input logic [CFG_W-1:0] cfg_wdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.verdict <= V_FOUND) && (m_data.block_level < 7'd100))
        else $error("verdict or level out of range");

    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict != V_FOUND) |-> m_data.found_level == '0)
        else $error("found level without calibration result");

    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict != V_PREROLL) |-> !m_data.preroll_slot)
        else $error("pre-roll slot outside pre-roll verdict");

endmodule

bind speech_endpoint_detector_core sed_checker u_sed_checker (.*);

// File: dv/speech_endpoint_detector_core_tb.sv
`timescale 1ns / 100ps

module speech_endpoint_detector_core_tb;
    import sed_pkg::*;

    localparam logic [1:0] ACT_UNDEFINED  = 2'd3;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam int         SETTLE_CYCLES  = 64;
    localparam int         WATCHDOG_NS    = 250_000_000;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    sed_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    sed_out_t         m_data;
    logic             cfg_we    = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int mismatch_count = 0;

    // register copies, reset values
    logic [1:0]  reg_mode         = MODE_DETECT;
    logic [6:0]  reg_start_level  = 7'd0;
    logic [6:0]  reg_stop_level   = 7'd3;
    logic [3:0]  reg_quiet_needed = 4'd4;
    logic [3:0]  reg_tail_blocks  = 4'd1;
    logic [11:0] reg_capacity     = 12'd1500;
    logic [7:0]  reg_calib_blocks = 8'd50;

    // detector state as the block should hold it
    logic [1:0]  det_phase      = PH_IDLE;
    int          det_pos        = 0;
    logic [14:0] det_peak       = '0;
    logic [3:0]  det_quiet      = '0;
    logic [3:0]  det_tail_left  = '0;
    logic [11:0] det_stored     = '0;
    int          det_ring_ptr   = 0;
    int          det_sum        = 0;
    int          det_count      = 0;
    int          det_min        = 1000;
    int          det_calib_left = 0;

    sed_out_t expected_reports[$];

    speech_endpoint_detector_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("Mismatches found");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    function automatic logic [2:0] claim_store_slot();
        if (int'(det_stored) + 1 < int'(reg_capacity)) begin
            det_stored++;
            return V_STORE;
        end
        return V_DISCARD;
    endfunction

    function automatic void predict_block_report(input sed_in_t req);
        sed_out_t rep;
        int       lvl;
        int       found;
        int       room;
        int       margin;
        logic     slot;
        if (req.action == ACT_ARM) begin
            det_phase      = PH_WAIT;
            det_pos        = 0;
            det_peak       = '0;
            det_quiet      = '0;
            det_tail_left  = reg_tail_blocks;
            det_stored     = '0;
            det_ring_ptr   = 0;
            det_sum        = 0;
            det_count      = 0;
            det_min        = 1000;
            det_calib_left = int'(reg_calib_blocks);
            return;
        end
        if (req.action == ACT_DISARM) begin
            det_phase = PH_IDLE;
            det_pos   = 0;
            det_peak  = '0;
            return;
        end
        if (req.action != ACT_SAMPLE || det_phase == PH_IDLE) return;

        // only non-negative samples can raise the peak
        if (!req.sample[15] && req.sample[14:0] > det_peak) det_peak = req.sample[14:0];
        det_pos++;
        if (det_pos < BLOCK_LEN) return;

        lvl      = (int'(det_peak) * 100) >> 15;
        det_pos  = 0;
        det_peak = '0;
        found    = 0;
        slot     = 1'b0;
        rep      = '0;
        rep.verdict = V_DISCARD;

        if (reg_mode == MODE_SILENCE) begin
            rep.verdict = V_SILENCE;
        end else if (reg_mode == MODE_START) begin
            if (det_calib_left <= 1) begin
                det_calib_left = 0;
                if (det_count > 0) found = (2 * (det_sum / det_count) + det_min) / 3;
                rep.verdict = V_FOUND;
                det_phase   = PH_IDLE;
            end else begin
                det_calib_left--;
                if (lvl > int'(reg_stop_level)) begin
                    det_sum += lvl;
                    det_count++;
                    if (lvl < det_min) det_min = lvl;
                end
            end
        end else if (reg_mode == MODE_DETECT) begin
            if (det_phase == PH_WAIT) begin
                slot         = det_ring_ptr[0];
                det_ring_ptr = (det_ring_ptr + 1) % PREROLL_BLOCKS;
                rep.verdict  = V_PREROLL;
                if (lvl >= int'(reg_start_level)) det_phase = PH_REC;
            end else if (det_phase == PH_TAIL) begin
                if (det_tail_left > 0) begin
                    det_tail_left--;
                    rep.verdict = claim_store_slot();
                end else begin
                    rep.verdict = V_END;
                    det_phase   = PH_IDLE;
                end
            end else if (det_quiet >= reg_quiet_needed) begin
                det_phase   = PH_TAIL;
                det_quiet   = '0;
                rep.verdict = V_SKIP;
            end else begin
                if (lvl <= int'(reg_stop_level)) begin
                    if (det_quiet < 4'd15) det_quiet++;
                end else begin
                    det_quiet = '0;
                end
                room   = int'(reg_capacity) - int'(det_stored);
                margin = 2 * (1 + int'(reg_tail_blocks) + PREROLL_BLOCKS);
                if (room < margin) det_phase = PH_TAIL;
                rep.verdict = claim_store_slot();
            end
        end

        rep.block_level  = LEVEL_W'(lvl);
        rep.found_level  = LEVEL_W'(found);
        rep.preroll_slot = slot;
        rep.recording    = (det_phase == PH_REC || det_phase == PH_TAIL);
        expected_reports.push_back(rep);
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        sed_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: no result expected, got verdict %0d level %0d",
                         $time, m_data.verdict, m_data.block_level);
            end else begin
                want = expected_reports.pop_front();
                check_field("verdict", want.verdict, m_data.verdict);
                check_field("block_level", want.block_level, m_data.block_level);
                check_field("found_level", want.found_level, m_data.found_level);
                check_field("preroll_slot", want.preroll_slot, m_data.preroll_slot);
                check_field("recording", want.recording, m_data.recording);
            end
        end
    end

    // valid drops only during a gap or while draining, so it is never lowered and raised in one step
    task automatic send_req(input sed_in_t req);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_block_report(req);
    endtask

    task automatic send_action(input logic [1:0] act);
        sed_in_t req;
        req.action = act;
        req.sample = 16'($urandom);
        send_req(req);
    endtask

    // one sample hits amp exactly, the rest stay at or below it or are negative
    task automatic send_samples(input int amp, input int count);
        sed_in_t req;
        int      hit;
        hit = $urandom_range(0, count - 1);
        for (int i = 0; i < count; i++) begin
            req.action = ACT_SAMPLE;
            if (i == hit) req.sample = 16'(amp);
            else if ($urandom_range(0, 7) == 0) req.sample = 16'(16'h8000 | $urandom);
            else req.sample = 16'($urandom_range(0, amp));
            send_req(req);
        end
    endtask

    task automatic send_level_block(input int lvl);
        send_samples((lvl * 32768 + 99) / 100, BLOCK_LEN);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input int val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MODE:     reg_mode         = val[1:0];
            CFG_START:    reg_start_level  = val[6:0];
            CFG_STOP:     reg_stop_level   = val[6:0];
            CFG_QUIET:    reg_quiet_needed = val[3:0];
            CFG_TAIL:     reg_tail_blocks  = val[3:0];
            CFG_CAPACITY: reg_capacity     = val[11:0];
            CFG_CALIB:    reg_calib_blocks = val[7:0];
            default: ;
        endcase
    endtask

    // pick a block level that moves the current phase along most of the time
    function automatic int steer_level();
        int start_lvl;
        int stop_lvl;
        start_lvl = int'(reg_start_level);
        stop_lvl  = int'(reg_stop_level);
        case (det_phase)
            PH_WAIT: begin
                if (start_lvl != 0 && $urandom_range(0, 2) == 0)
                    return $urandom_range(0, (start_lvl > 99) ? 99 : start_lvl - 1);
                return $urandom_range((start_lvl > 99) ? 99 : start_lvl, 99);
            end
            PH_REC: begin
                if (stop_lvl >= 99 || $urandom_range(0, 4) < 3)
                    return $urandom_range(0, (stop_lvl > 99) ? 99 : stop_lvl);
                return $urandom_range(stop_lvl + 1, 99);
            end
            default: return $urandom_range(0, 99);
        endcase
    endfunction

    task automatic test_power_on_defaults();
        sed_in_t req;
        // disarmed: samples, the undefined action and disarm do nothing
        send_samples(32767, 20);
        send_action(ACT_UNDEFINED);
        send_action(ACT_DISARM);
        send_action(ACT_ARM);
        req.action = ACT_SAMPLE;
        req.sample = 16'sh7fff;
        send_req(req);
        req.sample = 16'sh8000;
        send_req(req);
        req.sample = -16'sd1;
        send_req(req);
        req.sample = 16'sd0;
        send_req(req);
        req.sample = 16'sd1;
        send_req(req);
        send_samples(100, BLOCK_LEN - 5);
        send_samples(0, BLOCK_LEN);
        send_action(ACT_DISARM);
    endtask

    task automatic test_detect_thresholds();
        wait_drained();
        write_cfg(CFG_MODE, MODE_DETECT);
        write_cfg(CFG_START, 100);
        write_cfg(CFG_STOP, 0);
        write_cfg(CFG_QUIET, 0);
        write_cfg(CFG_TAIL, 0);
        write_cfg(CFG_CAPACITY, 4095);
        write_cfg(CFG_CALIB, 255);
        // start level out of reach: pre-roll ring keeps wrapping
        send_action(ACT_ARM);
        send_level_block(99);
        send_level_block(99);
        send_samples(1000, 700);
        send_action(ACT_ARM);
        send_level_block(99);
        send_action(ACT_DISARM);
        wait_drained();
        write_cfg(CFG_START, 99);
        send_action(ACT_ARM);
        send_level_block(99);
        send_level_block(0);
        send_level_block(0);
        wait_drained();
        write_cfg(CFG_QUIET, 15);
        write_cfg(CFG_TAIL, 15);
        send_action(ACT_ARM);
        send_level_block(99);
        send_level_block(0);
        send_level_block(0);
        send_action(ACT_DISARM);
    endtask

    task automatic test_store_limits();
        wait_drained();
        write_cfg(CFG_START, 0);
        write_cfg(CFG_STOP, 3);
        write_cfg(CFG_QUIET, 4);
        write_cfg(CFG_TAIL, 1);
        write_cfg(CFG_CAPACITY, 1);
        // store already full: recording and tail blocks are discarded
        send_action(ACT_ARM);
        repeat (4) send_level_block(60);
        wait_drained();
        write_cfg(CFG_TAIL, 0);
        write_cfg(CFG_CAPACITY, 7);
        // nearly full store cuts the recording short
        send_action(ACT_ARM);
        repeat (5) send_level_block(60);
    endtask

    task automatic test_silence_level();
        wait_drained();
        write_cfg(CFG_CAPACITY, 1500);
        write_cfg(CFG_MODE, MODE_SILENCE);
        send_action(ACT_ARM);
        send_level_block(0);
        send_samples(32767, BLOCK_LEN);
        send_level_block(37);
        send_action(ACT_DISARM);
    endtask

    task automatic test_start_level_calibration();
        wait_drained();
        write_cfg(CFG_MODE, MODE_START);
        write_cfg(CFG_STOP, 0);
        write_cfg(CFG_CALIB, 1);
        // no block counted: found level is zero
        send_action(ACT_ARM);
        send_level_block(80);
        wait_drained();
        write_cfg(CFG_STOP, 10);
        write_cfg(CFG_CALIB, 3);
        send_action(ACT_ARM);
        send_level_block(40);
        send_level_block(70);
        send_level_block(20);
        wait_drained();
        write_cfg(CFG_CALIB, 255);
        send_action(ACT_ARM);
        send_level_block(5);
        send_action(ACT_DISARM);
    endtask

    task automatic test_undefined_mode();
        wait_drained();
        write_cfg(CFG_MODE, MODE_UNDEFINED);
        send_action(ACT_ARM);
        send_level_block(99);
        send_action(ACT_DISARM);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int sessions);
        int         kind;
        int         block_cap;
        int         n;
        logic [1:0] mode;
        logic [1:0] cut_action;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        repeat (sessions) begin
            wait_drained();
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
                mode      = MODE_DETECT;
                block_cap = 12;
            end else if (kind < 14) begin
                mode      = MODE_SILENCE;
                block_cap = $urandom_range(1, 3);
            end else if (kind < 19) begin
                mode      = MODE_START;
                block_cap = 8;
            end else begin
                mode      = MODE_UNDEFINED;
                block_cap = 1;
            end
            write_cfg(CFG_MODE, mode);
            case ($urandom_range(0, 9))
                0: write_cfg(CFG_START, 0);
                1: write_cfg(CFG_START, 100);
                default: write_cfg(CFG_START, $urandom_range(5, 90));
            endcase
            case ($urandom_range(0, 9))
                0: write_cfg(CFG_STOP, 0);
                1: write_cfg(CFG_STOP, 100);
                default: write_cfg(CFG_STOP, $urandom_range(0, 30));
            endcase
            write_cfg(CFG_QUIET, ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 3));
            write_cfg(CFG_TAIL, ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: write_cfg(CFG_CAPACITY, 4095);
                1, 2, 3: write_cfg(CFG_CAPACITY, $urandom_range(1, 16));
                default: write_cfg(CFG_CAPACITY, $urandom_range(17, 4095));
            endcase
            write_cfg(CFG_CALIB, ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 4));

            if ($urandom_range(0, 3) == 0)
                send_samples($urandom_range(0, 32767), $urandom_range(1, 64));
            send_action(ACT_ARM);
            n = 0;
            while (det_phase != PH_IDLE && n < block_cap) begin
                // now and then break into a block with an arm, disarm or bad action
                if ($urandom_range(0, 11) == 0) begin
                    case ($urandom_range(0, 2))
                        0: cut_action = ACT_ARM;
                        1: cut_action = ACT_DISARM;
                        default: cut_action = ACT_UNDEFINED;
                    endcase
                    send_samples($urandom_range(0, 32767), $urandom_range(1, BLOCK_LEN - 1));
                    send_action(cut_action);
                end
                send_level_block(steer_level());
                n++;
            end
            if (det_phase != PH_IDLE) send_action(ACT_DISARM);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 38;
        recv_gap_pct = 77;
        test_power_on_defaults();
        test_detect_thresholds();
        test_store_limits();
        test_silence_level();
        test_start_level_calibration();
        test_undefined_mode();
        test_random_traffic(38, 77, 5);
        test_random_traffic(77, 38, 5);
        test_random_traffic(0, 0, 6);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
